### rtl/cross_stencil_5x5_filter_top_assert.svh
// Assertion macros for the checker file of the cross stencil filter
`ifndef CROSS_STENCIL_5X5_FILTER_TOP_ASSERT_SVH
`define CROSS_STENCIL_5X5_FILTER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CSF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/csf_pkg.sv
// Types and constants of the cross stencil filter
package csf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COORD_W    = 10;
	localparam int GEOM_W     = 11;
	localparam int VALUE_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int HALO       = 2;
	localparam int LINES      = 2 * HALO;
	localparam int WIN        = 2 * HALO + 1;
	localparam int LINE_WORD_W = LINES * SAMPLE_W;
	localparam int NTAPS      = 9;
	localparam int PROD_W     = 2 * SAMPLE_W;
	localparam int PSUM_W     = PROD_W + 2;
	localparam int TOTAL_W    = PROD_W + 4;
	localparam int SHIFT      = 8;
	localparam int QUOT_W     = TOTAL_W - SHIFT;

	localparam logic [GEOM_W-1:0] GEOM_MIN = GEOM_W'(5);
	localparam logic [GEOM_W-1:0] GEOM_MAX = GEOM_W'(1024);

	localparam logic signed [QUOT_W-1:0] SAT_HI = QUOT_W'(8388607);
	localparam logic signed [QUOT_W-1:0] SAT_LO = -QUOT_W'(8388608);

	// tap order inside the cross
	localparam int TAP_C  = 0;
	localparam int TAP_NN = 1;
	localparam int TAP_NF = 2;
	localparam int TAP_SN = 3;
	localparam int TAP_SF = 4;
	localparam int TAP_WN = 5;
	localparam int TAP_WF = 6;
	localparam int TAP_EN = 7;
	localparam int TAP_EF = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LINE_WIDTH,
		CFG_FRAME_HEIGHT,
		CFG_COEF_CENTER,
		CFG_COEF_NORTH,
		CFG_COEF_SOUTH,
		CFG_COEF_WEST,
		CFG_COEF_EAST
	} cfg_reg_e;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef sample_t tap_arr_t [NTAPS];

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
	} csf_tag_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		csf_tag_t                  tag;
	} csf_res_t;

endpackage

### rtl/csf_stream_if.sv
// Stream interfaces for samples in and filtered results out
interface csf_in_if;
	import csf_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface csf_out_if;
	import csf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] filtered_value;
	logic [COORD_W-1:0]        center_row;
	logic [COORD_W-1:0]        center_col;
	logic                      last_of_frame;
	modport source (output valid, output filtered_value, output center_row,
		output center_col, output last_of_frame, input ready);
	modport sink (input valid, input filtered_value, input center_row,
		input center_col, input last_of_frame, output ready);
endinterface

### rtl/cross_stencil_5x5_filter_top.sv
// A result passes stage 1, the window, the product and partial-sum registers and the output
//   register after the beat of the sample two rows below and two columns right of its center.
// Throughput: one sample per cycle while not stalled; per column one RAM read and write-back.
// The four line buffers share one RAM word per column, read at accept, written from stage 1.
// Reset clears counters, window, pipeline and output valid flags; the line RAM is not cleared.
module cross_stencil_5x5_filter_top #(
	parameter int MAX_LINE = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [csf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [csf_pkg::CFG_DATA_W-1:0]  cfg_data,
	csf_in_if.sink                          pixels,
	csf_out_if.source                       results
);
	import csf_pkg::*;

	localparam int AW = $clog2(MAX_LINE);
	localparam logic [GEOM_W-1:0] WMAX = GEOM_W'(MAX_LINE < 1024 ? MAX_LINE : 1024);

	// configuration
	logic [GEOM_W-1:0]     line_width_q;
	logic [GEOM_W-1:0]     frame_height_q;
	sample_t               coef_center_q;
	logic [CFG_DATA_W-1:0] coef_north_q;
	logic [CFG_DATA_W-1:0] coef_south_q;
	logic [CFG_DATA_W-1:0] coef_west_q;
	logic [CFG_DATA_W-1:0] coef_east_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= GEOM_MAX;
			frame_height_q <= GEOM_MAX;
			coef_center_q  <= sample_t'(256);
			coef_north_q   <= '0;
			coef_south_q   <= '0;
			coef_west_q    <= '0;
			coef_east_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINE_WIDTH:   line_width_q   <= cfg_data[GEOM_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[GEOM_W-1:0];
				CFG_COEF_CENTER:  coef_center_q  <= cfg_data[SAMPLE_W-1:0];
				CFG_COEF_NORTH:   coef_north_q   <= cfg_data;
				CFG_COEF_SOUTH:   coef_south_q   <= cfg_data;
				CFG_COEF_WEST:    coef_west_q    <= cfg_data;
				CFG_COEF_EAST:    coef_east_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [GEOM_W-1:0] w_use, h_use, w_last, h_last;

	always_comb begin
		if (line_width_q < GEOM_MIN) begin
			w_use = GEOM_MIN;
		end else if (line_width_q > WMAX) begin
			w_use = WMAX;
		end else begin
			w_use = line_width_q;
		end
		if (frame_height_q < GEOM_MIN) begin
			h_use = GEOM_MIN;
		end else if (frame_height_q > GEOM_MAX) begin
			h_use = GEOM_MAX;
		end else begin
			h_use = frame_height_q;
		end
		w_last = w_use - GEOM_W'(1);
		h_last = h_use - GEOM_W'(1);
	end

	// handshake and pipeline advance
	logic     adv, acc;
	logic     skid_valid_q, out_valid_q;
	csf_res_t skid_q, out_q;

	assign adv          = !skid_valid_q;
	assign pixels.ready = adv;
	assign acc          = pixels.valid && adv;

	// raster position of the incoming sample
	logic [COORD_W-1:0] col_count_q, row_count_q;
	logic               col_wrap, row_wrap, emit_now, last_now;

	assign col_wrap = {1'b0, col_count_q} >= w_last;
	assign row_wrap = {1'b0, row_count_q} >= h_last;
	assign emit_now = (row_count_q >= COORD_W'(2 * HALO)) && (col_count_q >= COORD_W'(2 * HALO));
	assign last_now = row_wrap && col_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (acc) begin
			if (col_wrap) begin
				col_count_q <= '0;
				row_count_q <= row_wrap ? '0 : row_count_q + COORD_W'(1);
			end else begin
				col_count_q <= col_count_q + COORD_W'(1);
			end
		end
	end

	// stage 1: line RAM read in flight
	logic           v_s1, emit_s1;
	sample_t        smp_s1;
	logic [AW-1:0]  addr_s1;
	csf_tag_t       tag_s1;
	logic [LINE_WORD_W-1:0] rd_word;
	logic [LINE_WORD_W-1:0] wr_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			smp_s1     <= pixels.sample_in;
			addr_s1    <= AW'(col_count_q);
			emit_s1    <= emit_now;
			tag_s1.row <= row_count_q - COORD_W'(HALO);
			tag_s1.col <= col_count_q - COORD_W'(HALO);
			tag_s1.last <= last_now;
		end
	end

	// oldest line sits in the top slice; the word shifts up one line per write
	assign wr_word = {rd_word[LINE_WORD_W-SAMPLE_W-1:0], smp_s1};

	csf_ram #(
		.WIDTH (LINE_WORD_W),
		.DEPTH (MAX_LINE)
	) u_lines (
		.clk   (clk),
		.we    (adv && v_s1),
		.waddr (addr_s1),
		.wdata (wr_word),
		.re    (acc),
		.raddr (AW'(col_count_q)),
		.rdata (rd_word)
	);

	// stage 2: 5x5 window
	sample_t  win_q [WIN][WIN];
	sample_t  col_in [WIN];
	logic     v_s2;
	csf_tag_t tag_s2;

	always_comb begin
		for (int r = 0; r < LINES; r++) begin
			col_in[r] = rd_word[SAMPLE_W*(LINES-1-r) +: SAMPLE_W];
		end
		col_in[LINES] = smp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < WIN; r++) begin
				for (int k = 0; k < WIN; k++) begin
					win_q[r][k] <= '0;
				end
			end
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && emit_s1;
			if (v_s1) begin
				for (int r = 0; r < WIN; r++) begin
					for (int k = 0; k < WIN - 1; k++) begin
						win_q[r][k] <= win_q[r][k+1];
					end
					win_q[r][WIN-1] <= col_in[r];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag_s1;
		end
	end

	tap_arr_t taps, coefs;

	always_comb begin
		taps[TAP_C]  = win_q[HALO][HALO];
		taps[TAP_NN] = win_q[HALO-1][HALO];
		taps[TAP_NF] = win_q[HALO-2][HALO];
		taps[TAP_SN] = win_q[HALO+1][HALO];
		taps[TAP_SF] = win_q[HALO+2][HALO];
		taps[TAP_WN] = win_q[HALO][HALO-1];
		taps[TAP_WF] = win_q[HALO][HALO-2];
		taps[TAP_EN] = win_q[HALO][HALO+1];
		taps[TAP_EF] = win_q[HALO][HALO+2];
		coefs[TAP_C]  = coef_center_q;
		coefs[TAP_NN] = coef_north_q[SAMPLE_W-1:0];
		coefs[TAP_NF] = coef_north_q[CFG_DATA_W-1:SAMPLE_W];
		coefs[TAP_SN] = coef_south_q[SAMPLE_W-1:0];
		coefs[TAP_SF] = coef_south_q[CFG_DATA_W-1:SAMPLE_W];
		coefs[TAP_WN] = coef_west_q[SAMPLE_W-1:0];
		coefs[TAP_WF] = coef_west_q[CFG_DATA_W-1:SAMPLE_W];
		coefs[TAP_EN] = coef_east_q[SAMPLE_W-1:0];
		coefs[TAP_EF] = coef_east_q[CFG_DATA_W-1:SAMPLE_W];
	end

	// stages 3 and 4
	logic     mac_valid;
	csf_res_t mac_res;

	csf_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s2),
		.in_tag    (tag_s2),
		.taps      (taps),
		.coefs     (coefs),
		.res_valid (mac_valid),
		.res       (mac_res)
	);

	// output register with skid; the skid fills only while the output beat is stalled
	logic new_res, load_out, load_skid;

	assign new_res   = adv && mac_valid;
	assign load_out  = new_res && (!out_valid_q || results.ready);
	assign load_skid = new_res && out_valid_q && !results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q && results.ready) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_skid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && results.ready) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= mac_res;
		end
		if (load_skid) begin
			skid_q <= mac_res;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.filtered_value = out_q.value;
	assign results.center_row     = out_q.tag.row;
	assign results.center_col     = out_q.tag.col;
	assign results.last_of_frame  = out_q.tag.last;

endmodule

### rtl/csf_ram.sv
// Generic simple dual-port RAM with registered read
module csf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/csf_mac.sv
// Nine-tap multiply, add tree, floor shift and saturation
module csf_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  csf_pkg::csf_tag_t in_tag,
	input  csf_pkg::tap_arr_t taps,
	input  csf_pkg::tap_arr_t coefs,
	output logic              res_valid,
	output csf_pkg::csf_res_t res
);
	import csf_pkg::*;

	logic signed [PROD_W-1:0] prod_s3 [NTAPS];
	logic                     v_s3;
	csf_tag_t                 tag_s3;
	logic signed [PSUM_W-1:0] psum_s4 [3];
	logic                     v_s4;
	csf_tag_t                 tag_s4;
	logic signed [TOTAL_W-1:0] total;
	logic signed [QUOT_W-1:0]  quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s3 <= in_valid;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NTAPS; i++) begin
				prod_s3[i] <= PROD_W'(taps[i]) * PROD_W'(coefs[i]);
			end
			tag_s3 <= in_tag;
			for (int j = 0; j < 3; j++) begin
				psum_s4[j] <= PSUM_W'(prod_s3[3*j]) + PSUM_W'(prod_s3[3*j+1])
					+ PSUM_W'(prod_s3[3*j+2]);
			end
			tag_s4 <= tag_s3;
		end
	end

	always_comb begin
		total = TOTAL_W'(psum_s4[0]) + TOTAL_W'(psum_s4[1]) + TOTAL_W'(psum_s4[2]);
		// arithmetic shift gives floor rounding
		quot = QUOT_W'(total >>> SHIFT);
		res.tag = tag_s4;
		if (quot > SAT_HI) begin
			res.value = SAT_HI[VALUE_W-1:0];
		end else if (quot < SAT_LO) begin
			res.value = SAT_LO[VALUE_W-1:0];
		end else begin
			res.value = quot[VALUE_W-1:0];
		end
	end

	assign res_valid = v_s4;

endmodule

### rtl/csf_checker.sv
// Port-level checker for the cross stencil filter, bound to the top level
`include "cross_stencil_5x5_filter_top_assert.svh"

module csf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [csf_pkg::VALUE_W-1:0]  filtered_value,
	input logic [csf_pkg::COORD_W-1:0]         center_row,
	input logic [csf_pkg::COORD_W-1:0]         center_col,
	input logic                                last_of_frame
);
	import csf_pkg::*;

	`CSF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
	`CSF_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable({filtered_value, center_row, center_col, last_of_frame}), "result payload changed while stalled")
	`CSF_ASSERT_IMPL(a_margin, clk, arst_n, out_valid, (center_row >= COORD_W'(HALO)) && (center_col >= COORD_W'(HALO)), "result center inside the border margin")
	`CSF_ASSERT_IMPL(a_stall_cause, clk, arst_n, !in_ready, out_valid, "input stalled with no result waiting")

endmodule

bind cross_stencil_5x5_filter_top csf_checker u_csf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (pixels.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.filtered_value (results.filtered_value),
	.center_row     (results.center_row),
	.center_col     (results.center_col),
	.last_of_frame  (results.last_of_frame)
);

### verif/tb_top.sv
// Self-checking testbench for the nine-tap cross stencil filter
`timescale 1ns / 100ps

module tb_top;
	import csf_pkg::*;

	localparam int unsigned LINE_MAX   = 1024;
	localparam int          QUIET_MAX  = 2000;
	localparam int          SETTLE_CYC = 8;
	localparam int          RAND_ITEMS = 520;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

	typedef enum {FILL_DIRECTED, FILL_EXTREME, FILL_FLAT, FILL_SMALL, FILL_FULL} fill_e;

	// Tracks geometry, weights, line buffers and window; predicts one sum per interior center.
	class stencil_board;
		logic [GEOM_W-1:0] width_reg, height_reg;
		logic [15:0]       center_w;
		logic [31:0]       north_w, south_w, west_w, east_w;
		sample_t           lines [LINES*LINE_MAX];
		sample_t           win [WIN][WIN];
		int unsigned       row_cnt, col_cnt;
		csf_res_t          expected_sums [$];
		int                errors;

		function new();
			width_reg = 11'd1024;
			height_reg = 11'd1024;
			center_w = 16'h0100;
			north_w = '0;
			south_w = '0;
			west_w = '0;
			east_w = '0;
			foreach (lines[i]) lines[i] = '0;
			foreach (win[r, k]) win[r][k] = '0;
			row_cnt = 0;
			col_cnt = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
			case (idx)
				CFG_LINE_WIDTH: width_reg = d[GEOM_W-1:0];
				CFG_FRAME_HEIGHT: height_reg = d[GEOM_W-1:0];
				CFG_COEF_CENTER: center_w = d[15:0];
				CFG_COEF_NORTH: north_w = d;
				CFG_COEF_SOUTH: south_w = d;
				CFG_COEF_WEST: west_w = d;
				CFG_COEF_EAST: east_w = d;
				default: ;
			endcase
		endfunction

		function int unsigned clamp_geom(logic [GEOM_W-1:0] v);
			return (v < 5) ? 5 : ((v > 1024) ? 1024 : int'(v));
		endfunction

		function longint tap(sample_t px, logic [15:0] wt);
			return longint'(px) * longint'(signed'(wt));
		endfunction

		function int pending();
			return expected_sums.size();
		endfunction

		function void note_sample(sample_t s);
			int unsigned w, h, c;
			sample_t     column [WIN];
			longint      acc;
			csf_res_t    r;
			w = clamp_geom(width_reg);
			h = clamp_geom(height_reg);
			c = col_cnt % LINE_MAX;
			// oldest row first, new sample last
			for (int k = 0; k < LINES; k++)
				column[k] = lines[(LINES - 1 - k) * LINE_MAX + c];
			column[LINES] = s;
			for (int k = LINES - 1; k > 0; k--)
				lines[k * LINE_MAX + c] = lines[(k - 1) * LINE_MAX + c];
			lines[c] = s;
			for (int rr = 0; rr < WIN; rr++) begin
				for (int k = 0; k < WIN - 1; k++)
					win[rr][k] = win[rr][k + 1];
				win[rr][WIN - 1] = column[rr];
			end
			if (row_cnt >= 2 * HALO && col_cnt >= 2 * HALO) begin
				acc = tap(win[2][2], center_w)
					+ tap(win[1][2], north_w[15:0]) + tap(win[0][2], north_w[31:16])
					+ tap(win[3][2], south_w[15:0]) + tap(win[4][2], south_w[31:16])
					+ tap(win[2][1], west_w[15:0]) + tap(win[2][0], west_w[31:16])
					+ tap(win[2][3], east_w[15:0]) + tap(win[2][4], east_w[31:16]);
				acc = acc >>> SHIFT;	// floor
				if (acc > 64'sd8388607)
					acc = 64'sd8388607;
				if (acc < -64'sd8388608)
					acc = -64'sd8388608;
				r.value = acc[VALUE_W-1:0];
				r.tag.row = COORD_W'(row_cnt - HALO);
				r.tag.col = COORD_W'(col_cnt - HALO);
				r.tag.last = (row_cnt >= h - 1 && col_cnt >= w - 1);
				expected_sums.push_back(r);
			end
			if (col_cnt >= w - 1) begin
				col_cnt = 0;
				row_cnt = (row_cnt >= h - 1) ? 0 : ((row_cnt + 1) & 10'h3FF);
			end else begin
				col_cnt = (col_cnt + 1) & 10'h3FF;
			end
		endfunction

		function void check_result(logic signed [VALUE_W-1:0] v, logic [COORD_W-1:0] row,
			logic [COORD_W-1:0] col, logic last);
			csf_res_t e;
			if (expected_sums.size() == 0) begin
				$error("result with nothing pending: row %0d col %0d value %0d", row, col, v);
				errors++;
				return;
			end
			e = expected_sums.pop_front();
			if (v !== e.value) begin
				$error("filtered_value: expected %0d, got %0d", e.value, v);
				errors++;
			end
			if (row !== e.tag.row) begin
				$error("center_row: expected %0d, got %0d", e.tag.row, row);
				errors++;
			end
			if (col !== e.tag.col) begin
				$error("center_col: expected %0d, got %0d", e.tag.col, col);
				errors++;
			end
			if (last !== e.tag.last) begin
				$error("last_of_frame: expected %0d, got %0d", e.tag.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	csf_in_if  pix_if ();
	csf_out_if res_if ();

	cross_stencil_5x5_filter_top #(
		.MAX_LINE(LINE_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixels(pix_if),
		.results(res_if)
	);

	stencil_board sb = new();
	bit           calm = 0;
	int           quiet_cycles = 0;
	int           rand_items = 0;

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// result side: check, random backpressure, watchdog
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result(res_if.filtered_value, res_if.center_row, res_if.center_col,
				res_if.last_of_frame);
		if (!arst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("tb_top: errors");
			$finish;
		end
		res_if.ready <= calm || ($urandom_range(0, 99) >= 19);
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.set_reg(idx, d);
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'h0100;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic set_geometry(int unsigned w_raw, int unsigned h_raw);
		logic [31:0] d;
		// junk above the field must be dropped
		d = $urandom;
		d[GEOM_W-1:0] = w_raw[GEOM_W-1:0];
		cfg_write(CFG_LINE_WIDTH, d);
		d = $urandom;
		d[GEOM_W-1:0] = h_raw[GEOM_W-1:0];
		cfg_write(CFG_FRAME_HEIGHT, d);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_coefs();
		bit          uniform;
		logic [15:0] u;
		logic [31:0] d;
		// uniform extreme weights push the sum into saturation
		uniform = ($urandom_range(0, 3) == 0);
		u = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		d = $urandom;
		d[15:0] = uniform ? u : pick_weight();
		cfg_write(CFG_COEF_CENTER, d);
		for (int i = CFG_COEF_NORTH; i <= CFG_COEF_EAST; i++)
			cfg_write(CFG_IDX_W'(i), uniform ? {u, u} : {pick_weight(), pick_weight()});
		if ($urandom_range(0, 1))
			cfg_write(CFG_SPARE_IDX, $urandom);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending, let every pending result out, then let the pipeline empty
	task automatic quiesce();
		pix_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic send_sample(sample_t s);
		while (!calm && $urandom_range(0, 99) < 19) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.sample_in <= s;
		do @(posedge clk); while (!pix_if.ready);
		sb.note_sample(s);
	endtask

	function automatic sample_t gen_sample(fill_e mode, sample_t flat, int idx, int w);
		case (mode)
			FILL_DIRECTED: begin
				// cross of the single center at most negative, border cycles extremes
				if (idx / w == 2 || idx % w == 2)
					return 16'sh8000;
				case (idx % 5)
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					3: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			FILL_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return -16'sd1;
				endcase
			end
			FILL_FLAT: return flat;
			FILL_SMALL: return sample_t'(int'($urandom_range(0, 600)) - 300);
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_frame(fill_e mode, bit drain);
		int      w, h, n, drain_at;
		sample_t flat;
		w = sb.clamp_geom(sb.width_reg);
		h = sb.clamp_geom(sb.height_reg);
		n = w * h;
		drain_at = drain ? $urandom_range(0, n - 1) : -1;
		flat = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		for (int i = 0; i < n; i++) begin
			if (i == drain_at) begin
				quiesce();
				if ($urandom_range(0, 1))
					set_coefs();
			end
			send_sample(gen_sample(mode, flat, i, w));
		end
	endtask

	initial begin
		int    wr, hr, frames, phase;
		fill_e mode;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_if.valid = 1'b0;
		pix_if.sample_in = '0;
		res_if.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single 5x5 frame, center weight left at reset, all arms at most negative
		set_geometry(5, 5);
		for (int i = CFG_COEF_NORTH; i <= CFG_COEF_EAST; i++)
			cfg_write(CFG_IDX_W'(i), 32'h8000_8000);
		cfg_we <= 1'b0;
		@(posedge clk);
		send_frame(FILL_DIRECTED, 1'b0);
		quiesce();

		// wide line, height below range, no idling on either side
		calm = 1;
		set_geometry(48, 4);
		set_coefs();
		send_frame(FILL_FULL, 1'b0);
		quiesce();
		calm = 0;

		// width below range
		set_geometry(3, 10);
		set_coefs();
		send_frame(FILL_FULL, 1'b0);
		quiesce();

		phase = 0;
		while (rand_items < RAND_ITEMS) begin
			case ($urandom_range(0, 9))
				0: wr = $urandom_range(0, 4);
				1: wr = 5;
				default: wr = $urandom_range(5, 16);
			endcase
			case ($urandom_range(0, 9))
				0: hr = $urandom_range(0, 4);
				1: hr = 5;
				default: hr = $urandom_range(5, 10);
			endcase
			set_geometry(wr, hr);
			set_coefs();
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				case ($urandom_range(0, 5))
					0: mode = FILL_EXTREME;
					1: mode = FILL_FLAT;
					2: mode = FILL_SMALL;
					default: mode = FILL_FULL;
				endcase
				send_frame(mode, (phase == 0 && f == 0) || $urandom_range(0, 5) == 0);
				rand_items += sb.clamp_geom(sb.width_reg) * sb.clamp_geom(sb.height_reg);
			end
			quiesce();
			phase++;
		end

		if (sb.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
